@@ rtl/core/assert_macros.svh @@
// assertion macros used by sector_read_cache_tags.sv
// no dependencies; the caller provides clock and reset signals in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define CHK_PROP(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/srct_pkg.sv @@
// shared types and constants of the sector read cache tag controller
// no dependencies
package srct_pkg;

   localparam int SLOTS        = 4;
   localparam int SLOT_SECTORS = 16;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int MASK_N = (SLOTS < 4) ? SLOTS : 4;

   localparam int SECTOR_W  = 32;
   localparam int COUNT_W   = 16;
   localparam int OP_W      = 2;
   localparam int OUTCOME_W = 3;
   localparam int SLOT_W    = 2;
   localparam int OFFSET_W  = 4;
   localparam int MASK_W    = 4;
   localparam int COUNTER_W = 32;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUT_BYPASS    = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_HIT       = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_FILLED    = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FILL_FAIL = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_WRITE     = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_CLEARED   = 3'd5;

   typedef logic [IDX_W-1:0] slot_idx_type;

   typedef struct packed {
      logic                wr_en;
      slot_idx_type        wr_addr;
      logic [SECTOR_W-1:0] wr_data;
      logic                rd_en;
      slot_idx_type        rd_addr;
   } tag_ram_req_type;

endpackage

@@ rtl/core/srct_tag_ram.sv @@
// start-sector tag store, one entry per slot, registered read
// depends on srct_pkg
module srct_tag_ram
   import srct_pkg::*;
(
   input  logic                clock,
   input  tag_ram_req_type     ram_req,
   output logic [SECTOR_W-1:0] rd_data
);

   logic [SECTOR_W-1:0] mem [SLOTS];
   logic [SECTOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/srct_ctrl.sv @@
// request sequencer: bypass check, slot scan over the tag store, fill, invalidate, clear
// depends on srct_pkg and drives srct_tag_ram through a request struct
module srct_ctrl
   import srct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SECTOR_W-1:0]  req_sector,
   input  logic [COUNT_W-1:0]   req_count,
   input  logic                 req_backing_read_ok,
   input  logic [SECTOR_W-1:0]  disk_sectors,
   output tag_ram_req_type      ram_req,
   input  logic [SECTOR_W-1:0]  ram_rd_data,
   output logic                 rsp_strobe,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [OFFSET_W-1:0]  rsp_sector_offset,
   output logic [MASK_W-1:0]    rsp_invalidated_mask,
   output logic [COUNTER_W-1:0] rsp_hit_count,
   output logic [COUNTER_W-1:0] rsp_miss_count,
   output logic [COUNTER_W-1:0] rsp_write_count
);

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type              state_ff, state_in;
   logic                   is_write_ff, is_write_in;
   logic [SECTOR_W-1:0]    sec_ff, sec_in;
   logic [SECTOR_W:0]      end_ff, end_in;
   logic                   ok_ff, ok_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   slot_idx_type           cmp_idx_ff, cmp_idx_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   slot_idx_type           ptr_ff, ptr_in;
   logic [SLOTS-1:0]       mask_ff, mask_in;
   logic [COUNTER_W-1:0]   hits_ff, hits_in;
   logic [COUNTER_W-1:0]   misses_ff, misses_in;
   logic [COUNTER_W-1:0]   writes_ff, writes_in;
   logic                   strobe_ff, strobe_in;
   logic [OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [MASK_W-1:0]      omask_ff, omask_in;

   always_comb begin
      logic                 bypass;
      logic [SECTOR_W:0]    st;
      logic [SECTOR_W:0]    top;
      logic                 hit;
      logic                 overlap;
      logic                 last;
      logic                 any_free;
      slot_idx_type         free_idx;
      slot_idx_type         ptr_next;
      slot_idx_type         pick;
      logic [SLOTS-1:0]     mask_next;
      logic [SECTOR_W-1:0]  diff;

      state_in    = state_ff;
      is_write_in = is_write_ff;
      sec_in      = sec_ff;
      end_in      = end_ff;
      ok_in       = ok_ff;
      iss_in      = iss_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      valid_in    = valid_ff;
      ptr_in      = ptr_ff;
      mask_in     = mask_ff;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      writes_in   = writes_ff;
      strobe_in   = 1'b0;
      outcome_in  = outcome_ff;
      slot_in     = slot_ff;
      offset_in   = offset_ff;
      omask_in    = omask_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = '0;
      ram_req.wr_data = sec_ff;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = iss_ff[IDX_W-1:0];

      // sums kept one bit wider so they never wrap
      bypass = (req_count > COUNT_W'(SLOT_SECTORS)) ||
               (({1'b0, req_sector} + (SECTOR_W+1)'(SLOT_SECTORS)) >= {1'b0, disk_sectors});

      st      = {1'b0, ram_rd_data};
      top     = st + (SECTOR_W+1)'(SLOT_SECTORS);
      hit     = valid_ff[cmp_idx_ff] && ({1'b0, sec_ff} >= st) && (end_ff <= top);
      overlap = valid_ff[cmp_idx_ff] && ({1'b0, sec_ff} < top) && (end_ff > st);
      last    = (cmp_idx_ff == IDX_W'(SLOTS - 1));
      diff    = sec_ff - ram_rd_data;

      any_free = ~&valid_ff;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      ptr_next  = (ptr_ff == IDX_W'(SLOTS - 1)) ? '0 : IDX_W'(ptr_ff + 1'b1);
      pick      = any_free ? free_idx : ptr_next;
      mask_next = mask_ff;
      if (overlap) begin
         mask_next[cmp_idx_ff] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               is_write_in = (req_op == OP_WRITE);
               sec_in      = req_sector;
               end_in      = {1'b0, req_sector} + (SECTOR_W+1)'(req_count);
               ok_in       = req_backing_read_ok;
               iss_in      = '0;
               mask_in     = '0;
               unique case (req_op)
                  OP_READ: begin
                     if (bypass) begin
                        strobe_in  = 1'b1;
                        outcome_in = OUT_BYPASS;
                        slot_in    = '0;
                        offset_in  = '0;
                        omask_in   = '0;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_WRITE: begin
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: begin
                     valid_in   = '0;
                     ptr_in     = '0;
                     hits_in    = '0;
                     misses_in  = '0;
                     writes_in  = '0;
                     strobe_in  = 1'b1;
                     outcome_in = OUT_CLEARED;
                     slot_in    = '0;
                     offset_in  = '0;
                     omask_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // one tag read issued per cycle, compared in the cycle after
            if (iss_ff < CNT_W'(SLOTS)) begin
               ram_req.rd_en = 1'b1;
               iss_in        = CNT_W'(iss_ff + 1'b1);
               cmp_vld_in    = 1'b1;
               cmp_idx_in    = iss_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (is_write_ff) begin
                  mask_in = mask_next;
                  if (overlap) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                  end
                  if (last) begin
                     writes_in  = writes_ff + 1'b1;
                     strobe_in  = 1'b1;
                     outcome_in = OUT_WRITE;
                     slot_in    = '0;
                     offset_in  = '0;
                     omask_in   = MASK_W'(mask_next[MASK_N-1:0]);
                     state_in   = S_IDLE;
                  end
               end else if (hit) begin
                  hits_in    = hits_ff + 1'b1;
                  strobe_in  = 1'b1;
                  outcome_in = OUT_HIT;
                  slot_in    = SLOT_W'(cmp_idx_ff);
                  offset_in  = diff[OFFSET_W-1:0];
                  omask_in   = '0;
                  state_in   = S_IDLE;
               end else if (last) begin
                  misses_in = misses_ff + 1'b1;
                  if (!any_free) begin
                     ptr_in = ptr_next;
                  end
                  // tag commits only on a good backing read
                  if (ok_ff) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = pick;
                     valid_in[pick]  = 1'b1;
                     outcome_in      = OUT_FILLED;
                  end else begin
                     outcome_in = OUT_FILL_FAIL;
                  end
                  strobe_in = 1'b1;
                  slot_in   = SLOT_W'(pick);
                  offset_in = '0;
                  omask_in  = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         ptr_ff     <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         writes_ff  <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         ptr_ff     <= ptr_in;
         hits_ff    <= hits_in;
         misses_ff  <= misses_in;
         writes_ff  <= writes_in;
         strobe_ff  <= strobe_in;
      end
      is_write_ff <= is_write_in;
      sec_ff      <= sec_in;
      end_ff      <= end_in;
      ok_ff       <= ok_in;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      mask_ff     <= mask_in;
      outcome_ff  <= outcome_in;
      slot_ff     <= slot_in;
      offset_ff   <= offset_in;
      omask_ff    <= omask_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_slot             = slot_ff;
   assign rsp_sector_offset    = offset_ff;
   assign rsp_invalidated_mask = omask_ff;
   assign rsp_hit_count        = hits_ff;
   assign rsp_miss_count       = misses_ff;
   assign rsp_write_count      = writes_ff;

endmodule

@@ rtl/core/sector_read_cache_tags.sv @@
// top level of the sector read cache tag controller: csr register, sequencer, tag store
// depends on srct_pkg, srct_ctrl, srct_tag_ram and assert_macros.svh
//
// A request is taken when start is high and busy is low. Reads that bypass and clears
// answer in the cycle after the transfer; op code 3 is ignored; reads that reach the tag
// scan and all writes step through the tag store one slot per cycle (one read port,
// registered read), so a write scans every slot and a read scans up to the last slot,
// ending early on a hit. Each result shows for one cycle under rsp_strobe and
// must be taken then; busy is already low in that cycle, so the next request may be
// issued alongside it. The tag store is written only at the end of a miss, after the
// scan, so reads and writes never meet on an entry. csr writes are always ready and
// should only be made while no request is in flight.
`include "assert_macros.svh"

module sector_read_cache_tags
   import srct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SECTOR_W-1:0]  req_sector,
   input  logic [COUNT_W-1:0]   req_count,
   input  logic                 req_backing_read_ok,
   output logic                 rsp_strobe,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [OFFSET_W-1:0]  rsp_sector_offset,
   output logic [MASK_W-1:0]    rsp_invalidated_mask,
   output logic [COUNTER_W-1:0] rsp_hit_count,
   output logic [COUNTER_W-1:0] rsp_miss_count,
   output logic [COUNTER_W-1:0] rsp_write_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SECTOR_W-1:0]  csr_data
);

   logic [SECTOR_W-1:0] disk_ff;
   tag_ram_req_type     ram_req;
   logic [SECTOR_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         disk_ff <= csr_data;
      end
   end

   srct_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_sector           (req_sector),
      .req_count            (req_count),
      .req_backing_read_ok  (req_backing_read_ok),
      .disk_sectors         (disk_ff),
      .ram_req              (ram_req),
      .ram_rd_data          (ram_rd_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_outcome          (rsp_outcome),
      .rsp_slot             (rsp_slot),
      .rsp_sector_offset    (rsp_sector_offset),
      .rsp_invalidated_mask (rsp_invalidated_mask),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_miss_count       (rsp_miss_count),
      .rsp_write_count      (rsp_write_count)
   );

   srct_tag_ram u_tag_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // tag fill only happens after the scan has issued its last read
   `CHK_IMPLY(a_no_rw_overlap, ram_req.wr_en, !ram_req.rd_en, "tag store read and write overlap")

   // a clear transfer answers in the next cycle with zeroed counters
   `CHK_NEXT(a_clear_resp, start && !busy && (req_op == OP_CLEAR), rsp_strobe && (rsp_outcome == OUT_CLEARED) && (rsp_hit_count == '0) && (rsp_miss_count == '0) && (rsp_write_count == '0), "clear did not answer with zeroed counters")

   // a hit result comes with exactly one more hit counted
   `CHK_IMPLY(a_hit_count, rsp_strobe && (rsp_outcome == OUT_HIT), rsp_hit_count == COUNTER_W'($past(rsp_hit_count) + 1'b1), "hit counter out of step with hit result")

   // results are only shown once the sequencer is free again
   `CHK_IMPLY(a_strobe_idle, rsp_strobe, !busy, "result strobe while busy")

endmodule

@@ verif/sector_read_cache_tags_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of sector_read_cache_tags: directed table, then random traffic
// depends on srct_pkg and the rtl under rtl/core; expected replies come from a tag predictor
module sector_read_cache_tags_tb;
   import srct_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 250000;
   localparam int SETTLE_CYCLES   = SLOTS + 6;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int DIRECTED_N      = 24;
   localparam int DIR_AT_ZERO     = 2;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [SLOT_W-1:0]    slot;
      logic [OFFSET_W-1:0]  offset;
      logic [MASK_W-1:0]    mask;
      logic [COUNTER_W-1:0] hits;
      logic [COUNTER_W-1:0] misses;
      logic [COUNTER_W-1:0] writes;
   } cache_reply_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [SECTOR_W-1:0]  sector;
      logic [COUNT_W-1:0]   count;
      logic                 ok;
      logic                 typed;
      logic [OUTCOME_W-1:0] outcome;
      logic [SLOT_W-1:0]    slot;
      logic [OFFSET_W-1:0]  offset;
      logic [MASK_W-1:0]    mask;
   } dir_row_type;

   // rows before DIR_AT_ZERO run with a zero disk size, the rest with 4096 sectors
   localparam dir_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{OP_READ,  32'd0,          16'd1,      1'b1, 1'b1, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'd0,          16'd1,      1'b1, 1'b1, OUT_WRITE,     2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd0,          16'd1,      1'b1, 1'b1, OUT_FILLED,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd0,          16'd16,     1'b1, 1'b1, OUT_HIT,       2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd15,         16'd1,      1'b1, 1'b1, OUT_HIT,       2'd0, 4'd15, 4'd0},
      '{OP_READ,  32'd15,         16'd2,      1'b1, 1'b1, OUT_FILLED,    2'd1, 4'd0,  4'd0},
      '{OP_READ,  32'd100,        16'd0,      1'b0, 1'b1, OUT_FILL_FAIL, 2'd2, 4'd0,  4'd0},
      '{OP_READ,  32'd100,        16'd17,     1'b1, 1'b1, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd4080,       16'd1,      1'b1, 1'b1, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd4079,       16'd16,     1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd200,        16'd4,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd300,        16'd1,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd400,        16'd1,      1'b0, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd0,          16'd0,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'd10,         16'd1,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'd0,          16'hFFFF,   1'b0, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'hFFFF_FFFF,  16'hFFFF,   1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'hFFFF_FFFF,  16'hFFFF,   1'b1, 1'b1, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,   1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd64,         16'd16,     1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'd80,         16'd0,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_WRITE, 32'd79,         16'd0,      1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0},
      '{OP_CLEAR, 32'd0,          16'd0,      1'b0, 1'b1, OUT_CLEARED,   2'd0, 4'd0,  4'd0},
      '{OP_READ,  32'd5,          16'd16,     1'b1, 1'b0, OUT_BYPASS,    2'd0, 4'd0,  4'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_op = OP_READ;
   logic [SECTOR_W-1:0]  req_sector = '0;
   logic [COUNT_W-1:0]   req_count = '0;
   logic                 req_backing_read_ok = 1'b0;
   logic                 rsp_strobe;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [OFFSET_W-1:0]  rsp_sector_offset;
   logic [MASK_W-1:0]    rsp_invalidated_mask;
   logic [COUNTER_W-1:0] rsp_hit_count;
   logic [COUNTER_W-1:0] rsp_miss_count;
   logic [COUNTER_W-1:0] rsp_write_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SECTOR_W-1:0]  csr_data = '0;

   // typed expectation that travels with the request being offered
   logic                 row_typed = 1'b0;
   cache_reply_type      row_reply = '0;

   // predictor state
   logic [SECTOR_W-1:0]  tag_base [SLOTS];
   logic                 tag_live [SLOTS];
   int unsigned          victim_ptr;
   logic [COUNTER_W-1:0] hit_total, miss_total, write_total;
   logic [SECTOR_W-1:0]  disk_size;

   cache_reply_type      pending_replies [$];
   int unsigned          n_taken, n_csr_writes, n_checked, n_errors, cycle_count;
   int unsigned          outcome_tally [6];
   logic [SECTOR_W-1:0]  phase_disk [PHASES];
   int unsigned          phase_idle [PHASES];
   logic [SECTOR_W-1:0]  hot_base;

   sector_read_cache_tags u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_sector           (req_sector),
      .req_count            (req_count),
      .req_backing_read_ok  (req_backing_read_ok),
      .rsp_strobe           (rsp_strobe),
      .rsp_outcome          (rsp_outcome),
      .rsp_slot             (rsp_slot),
      .rsp_sector_offset    (rsp_sector_offset),
      .rsp_invalidated_mask (rsp_invalidated_mask),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_miss_count       (rsp_miss_count),
      .rsp_write_count      (rsp_write_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void drop_all_tags();
      for (int n = 0; n < SLOTS; n++) begin
         tag_base[n] = '0;
         tag_live[n] = 1'b0;
      end
      victim_ptr  = 0;
      hit_total   = '0;
      miss_total  = '0;
      write_total = '0;
   endfunction

   // returns 0 when the op produces no reply
   function automatic bit predict_tag_access(input logic [OP_W-1:0] op,
                                             input logic [SECTOR_W-1:0] sec,
                                             input logic [COUNT_W-1:0] cnt,
                                             input logic ok,
                                             output cache_reply_type rep);
      longint unsigned s, c, st, diff;
      int              pick;
      bit              found;
      s   = sec;
      c   = cnt;
      rep = '0;
      case (op)
         OP_READ: begin
            if (c > SLOT_SECTORS || s + SLOT_SECTORS >= longint'(disk_size)) begin
               rep.outcome = OUT_BYPASS;
            end else begin
               found = 1'b0;
               for (int n = 0; n < SLOTS; n++) begin
                  st = tag_base[n];
                  if (!found && tag_live[n] && s >= st && s + c <= st + SLOT_SECTORS) begin
                     found       = 1'b1;
                     hit_total   = hit_total + 1;
                     diff        = s - st;
                     rep.outcome = OUT_HIT;
                     rep.slot    = SLOT_W'(n);
                     rep.offset  = diff[OFFSET_W-1:0];
                  end
               end
               if (!found) begin
                  miss_total = miss_total + 1;
                  pick = 0;
                  for (int n = 0; n < SLOTS; n++) begin
                     if (!found && !tag_live[n]) begin
                        pick  = n;
                        found = 1'b1;
                     end
                  end
                  // no empty slot: pointer moves first, then names the victim
                  if (!found) begin
                     victim_ptr = (victim_ptr + 1 >= SLOTS) ? 0 : victim_ptr + 1;
                     pick       = victim_ptr;
                  end
                  rep.slot = SLOT_W'(pick);
                  if (ok) begin
                     tag_base[pick] = sec;
                     tag_live[pick] = 1'b1;
                     rep.outcome    = OUT_FILLED;
                  end else begin
                     rep.outcome = OUT_FILL_FAIL;
                  end
               end
            end
         end
         OP_WRITE: begin
            write_total = write_total + 1;
            for (int n = 0; n < SLOTS; n++) begin
               st = tag_base[n];
               if (tag_live[n] && s < st + SLOT_SECTORS && s + c > st) begin
                  tag_live[n] = 1'b0;
                  rep.mask[n] = 1'b1;
               end
            end
            rep.outcome = OUT_WRITE;
         end
         OP_CLEAR: begin
            drop_all_tags();
            rep.outcome = OUT_CLEARED;
         end
         default: return 1'b0;
      endcase
      rep.hits   = hit_total;
      rep.misses = miss_total;
      rep.writes = write_total;
      return 1'b1;
   endfunction

   task automatic check_field(input string what, input logic [COUNTER_W-1:0] want,
                              input logic [COUNTER_W-1:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // sampling side: replies, request transfers and csr transfers at the rising edge
   always @(posedge clock) begin
      cache_reply_type want, fresh;
      if (!reset) begin
         if (rsp_strobe) begin
            if (rsp_outcome < 6) outcome_tally[rsp_outcome]++;
            if (pending_replies.size() == 0) begin
               n_errors++;
               $display("%0t: reply with none expected, outcome %0d", $time, rsp_outcome);
            end else begin
               want = pending_replies.pop_front();
               n_checked++;
               check_field("outcome", want.outcome, rsp_outcome);
               check_field("slot", want.slot, rsp_slot);
               check_field("sector_offset", want.offset, rsp_sector_offset);
               check_field("invalidated_mask", want.mask, rsp_invalidated_mask);
               check_field("hit_count", want.hits, rsp_hit_count);
               check_field("miss_count", want.misses, rsp_miss_count);
               check_field("write_count", want.writes, rsp_write_count);
            end
         end
         if (start && !busy) begin
            n_taken++;
            if (predict_tag_access(req_op, req_sector, req_count, req_backing_read_ok,
                                   fresh)) begin
               if (row_typed) begin
                  fresh.outcome = row_reply.outcome;
                  fresh.slot    = row_reply.slot;
                  fresh.offset  = row_reply.offset;
                  fresh.mask    = row_reply.mask;
               end
               pending_replies.push_back(fresh);
            end
         end
         if (csr_valid && csr_ready) begin
            disk_size = csr_data;
            n_csr_writes++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // all driving tasks are entered at a falling edge and return at one
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [SECTOR_W-1:0] sec,
                                input logic [COUNT_W-1:0] cnt, input logic ok,
                                input logic typed, input cache_reply_type typed_rep);
      int unsigned seen;
      seen = n_taken;
      start               <= 1'b1;
      req_op              <= op;
      req_sector          <= sec;
      req_count           <= cnt;
      req_backing_read_ok <= ok;
      row_typed           <= typed;
      row_reply           <= typed_rep;
      do @(negedge clock); while (n_taken == seen);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clock);
   endtask

   // also covers an ignored op still in flight, which leaves nothing to wait for
   task automatic drain_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_disk_size(input logic [SECTOR_W-1:0] value);
      int unsigned seen;
      drain_replies();
      seen = n_csr_writes;
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(negedge clock); while (n_csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request(output logic [OP_W-1:0] op, output logic [SECTOR_W-1:0] sec,
                                 output logic [COUNT_W-1:0] cnt, output logic ok);
      int unsigned pct;
      pct = $urandom_range(0, 99);
      if (pct < 60)      op = OP_READ;
      else if (pct < 88) op = OP_WRITE;
      else if (pct < 91) op = OP_CLEAR;
      else if (pct < 94) op = OP_UNUSED;
      else               op = OP_READ;
      // mostly a narrow hot window so that slots get reused and overlap
      pct = $urandom_range(0, 99);
      if (pct < 70)      sec = hot_base + $urandom_range(0, 63);
      else if (pct < 80) sec = $urandom;
      else if (pct < 90) sec = disk_size - $urandom_range(0, 20);
      else               sec = 32'hFFFF_FFFF - $urandom_range(0, 20);
      pct = $urandom_range(0, 99);
      if (pct < 75)      cnt = COUNT_W'($urandom_range(0, SLOT_SECTORS));
      else if (pct < 85) cnt = COUNT_W'($urandom_range(SLOT_SECTORS + 1, 64));
      else if (pct < 95) cnt = COUNT_W'($urandom);
      else               cnt = 16'hFFFF;
      ok = ($urandom_range(0, 9) != 0);
   endtask

   initial begin
      dir_row_type         row;
      cache_reply_type     typed_rep;
      logic [OP_W-1:0]     op;
      logic [SECTOR_W-1:0] sec;
      logic [COUNT_W-1:0]  cnt;
      logic                ok;
      int unsigned         items;

      drop_all_tags();
      disk_size    = '0;
      n_taken      = 0;
      n_csr_writes = 0;
      n_checked    = 0;
      n_errors     = 0;
      cycle_count  = 0;
      foreach (outcome_tally[k]) outcome_tally[k] = 0;
      phase_disk = '{32'hFFFF_FFFF, 32'd64, 32'd0, 32'd17, 32'd0, 32'd4096};
      phase_disk[4] = $urandom;
      phase_idle = '{25, 10, 30, 0, 20, 0};
      hot_base = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         if (i == DIR_AT_ZERO) write_disk_size(32'd4096);
         row = DIRECTED_ROWS[i];
         typed_rep         = '0;
         typed_rep.outcome = row.outcome;
         typed_rep.slot    = row.slot;
         typed_rep.offset  = row.offset;
         typed_rep.mask    = row.mask;
         issue_request(row.op, row.sector, row.count, row.ok, row.typed, typed_rep);
         if ($urandom_range(0, 99) < 30) idle_burst();
      end

      for (int p = 0; p < PHASES; p++) begin
         write_disk_size(phase_disk[p]);
         hot_base = (disk_size > 200) ? $urandom_range(0, disk_size - 200) : '0;
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            random_request(op, sec, cnt, ok);
            issue_request(op, sec, cnt, ok, 1'b0, '0);
            if (op != OP_UNUSED) items++;
            // phases with a zero idle share (the fourth and the last) run back to back
            if (phase_idle[p] != 0) begin
               if ($urandom_range(0, 99) < phase_idle[p]) idle_burst();
               else if ($urandom_range(0, 99) < 3) drain_replies();
            end
         end
      end
      drain_replies();

      if (pending_replies.size() != 0) begin
         n_errors++;
         $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      end
      $display("%0d requests over %0d disk sizes, %0d replies checked, %0d errors",
               n_taken, n_csr_writes, n_checked, n_errors);
      $display("seen: %0d hits, %0d fills, %0d failed fills, %0d bypasses, %0d writes, %0d clears",
               outcome_tally[OUT_HIT], outcome_tally[OUT_FILLED], outcome_tally[OUT_FILL_FAIL],
               outcome_tally[OUT_BYPASS], outcome_tally[OUT_WRITE], outcome_tally[OUT_CLEARED]);
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/srct_pkg.sv
rtl/core/srct_tag_ram.sv
rtl/core/srct_ctrl.sv
rtl/core/sector_read_cache_tags.sv
verif/sector_read_cache_tags_tb.sv
